// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the console engine RTL.
// Plain header with an include guard; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked at every rising clock edge outside reset.
`define TCCE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle implication failed");

// Next-cycle implication checked at every rising clock edge outside reset.
`define TCCE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");

`endif

// ===== rtl/core/tcce_pkg.sv =====
// Shared constants for the text console character engine.
// No dependencies; used by the top level by scoped names.
package tcce_pkg;

   // Screen geometry and video memory size.
   localparam int COLUMNS      = 80;
   localparam int ROWS         = 25;
   localparam int MEMORY_CELLS = 8192;
   localparam int SCREEN_CELLS = ROWS * COLUMNS;

   // Derived widths.
   localparam int ADDR_W   = $clog2(MEMORY_CELLS);
   localparam int POS_W    = $clog2(MEMORY_CELLS + SCREEN_CELLS + COLUMNS + 1);
   localparam int CMP_W    = POS_W + 1;
   localparam int WALK_MAX = (MEMORY_CELLS > SCREEN_CELLS) ? MEMORY_CELLS : SCREEN_CELLS;
   localparam int CNT_W    = $clog2(WALK_MAX + 1);
   localparam int COL_W    = $clog2(COLUMNS + 1);
   localparam int ROW_W    = $clog2(ROWS);

   // Field widths of the channels.
   localparam int CMD_W       = 2;
   localparam int CHAR_W      = 8;
   localparam int CELL_W      = 16;
   localparam int OFFSET_W    = 13;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   // Commands.
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CHAR_ATTR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK     = 1'b1;

   // Configuration reset values.
   localparam logic [CHAR_W-1:0] ATTR_RESET  = 8'h07;
   localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;

   // Control bytes.
   localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
   localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
   localparam logic [CHAR_W-1:0] CH_HT  = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

endpackage

// ===== rtl/core/tcce_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/text_console_character_engine.sv =====
// Top level of the text console character engine: sequencer, position state and RAM.
// Depends on tcce_pkg, tcce_ram and assert_macros.svh.
//
// Usage: each request beat carries one command: write one byte to an 80x25 text screen
// in an 8192-cell video RAM, clear the RAM and all positions, or read one cell word.
// Every request beat yields one response beat with the latched cursor offset, the
// screen start offset and the read word (zero unless a read).
// An ignored byte, a cursor move, an erase or the unused command go from decode to the
// response register; a printed byte first passes ST_AFTER and a read ST_RDWAIT; a line
// feed or form feed inside the screen or a print that takes a pending wrap passes ST_LF
// and then ST_AFTER. A scroll blanks one row through the RAM write port; when memory is
// full the screen is first copied back to cell 0 one cell per cycle. A clear walks all
// 8192 cells before its response. The copy and the row blanking share one address adder,
// and all walks share the single RAM write port.
// Requests are taken one at a time: req_tready is high only while the sequencer idles,
// so a new request is taken only after the last one has reached the response register.
// After reset a blanking pass over all 8192 cells runs with req_tready low; configuration
// writes are taken at any time. A stalled receiver leaves the response in its
// register; one more request is then accepted and processed, and its response waits
// until the register frees up.
`include "assert_macros.svh"

module text_console_character_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // req_tdata fields from bit 0: command[1:0], char_code[9:2], read_cell[22:10], zero pad.
   input  logic [tcce_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                 req_tlast,  // end_of_buffer
   // Response channel.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // rsp_tdata fields from bit 0: cursor_register[12:0],
   // screen_start_register[25:13], read_data[41:26], zero pad.
   output logic [tcce_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // Configuration write port.
   input  logic                                 csr_we,
   input  logic [tcce_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [tcce_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_EXEC   = 9'b000000100,
      ST_RDWAIT = 9'b000001000,
      ST_LF     = 9'b000010000,
      ST_RELOC  = 9'b000100000,
      ST_BLANK  = 9'b001000000,
      ST_AFTER  = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   // What follows a line feed once the cursor has moved down.
   typedef enum logic [2:0] {
      AFT_NONE = 3'b001,
      AFT_CR   = 3'b010,
      AFT_PUT  = 3'b100
   } after_type;

   localparam int ADDR_W   = tcce_pkg::ADDR_W;
   localparam int POS_W    = tcce_pkg::POS_W;
   localparam int CMP_W    = tcce_pkg::CMP_W;
   localparam int CNT_W    = tcce_pkg::CNT_W;
   localparam int COL_W    = tcce_pkg::COL_W;
   localparam int ROW_W    = tcce_pkg::ROW_W;
   localparam int CHAR_W   = tcce_pkg::CHAR_W;
   localparam int CELL_W   = tcce_pkg::CELL_W;
   localparam int CMD_W    = tcce_pkg::CMD_W;
   localparam int OFFSET_W = tcce_pkg::OFFSET_W;

   // Control state.
   state_type           state_ff, state_in;
   after_type           after_ff, after_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [POS_W-1:0]    cursor_ff, cursor_in;
   logic [POS_W-1:0]    start_ff, start_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [POS_W-1:0]    latched_ff, latched_in;
   logic [CHAR_W-1:0]   attr_ff, attr_in;
   logic [CELL_W-1:0]   blank_ff, blank_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic                copy_v_ff, copy_v_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic                eob_ff, eob_in;
   logic [OFFSET_W-1:0] rdcell_ff, rdcell_in;
   logic [CELL_W-1:0]   data_ff, data_in;
   logic [POS_W-1:0]    walk_base_ff, walk_base_in;
   logic [CNT_W-1:0]    copy_dst_ff, copy_dst_in;
   logic                copy_oob_ff, copy_oob_in;
   logic [OFFSET_W-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic [OFFSET_W-1:0] rsp_start_ff, rsp_start_in;
   logic [CELL_W-1:0]   rsp_read_ff, rsp_read_in;

   // RAM port signals.
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [CELL_W-1:0]   ram_wdata;
   logic                ram_re;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [CELL_W-1:0]   ram_rdata;

   // Shared walk address adder and the bound checks around it.
   logic [CMP_W-1:0]    walk_addr;
   logic                walk_in_range;
   logic [POS_W-1:0]    cursor_m1;
   logic                cursor_in_range;
   logic                cursor_m1_in_range;
   logic                rdcell_in_range;
   logic                copy_dst_in_range;
   logic [ROW_W:0]      row_p1;
   logic                room_for_row;

   assign walk_addr          = CMP_W'(walk_base_ff) + CMP_W'(cnt_ff);
   assign walk_in_range      = walk_addr < CMP_W'(tcce_pkg::MEMORY_CELLS);
   assign cursor_m1          = cursor_ff - POS_W'(1);
   assign cursor_in_range    = CMP_W'(cursor_ff) < CMP_W'(tcce_pkg::MEMORY_CELLS);
   assign cursor_m1_in_range = CMP_W'(cursor_m1) < CMP_W'(tcce_pkg::MEMORY_CELLS);
   assign rdcell_in_range    = CMP_W'(rdcell_ff) < CMP_W'(tcce_pkg::MEMORY_CELLS);
   assign copy_dst_in_range  = CMP_W'(copy_dst_ff) < CMP_W'(tcce_pkg::MEMORY_CELLS);
   assign row_p1             = (ROW_W + 1)'(row_ff) + (ROW_W + 1)'(1);
   assign room_for_row       = (CMP_W'(start_ff) + CMP_W'(tcce_pkg::SCREEN_CELLS)
                                + CMP_W'(tcce_pkg::COLUMNS))
                               < CMP_W'(tcce_pkg::MEMORY_CELLS);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tcce_pkg::RSP_TDATA_W - 2 * OFFSET_W - CELL_W){1'b0}},
                        rsp_read_ff, rsp_start_ff, rsp_cursor_ff};

   always_comb begin
      state_in      = state_ff;
      after_in      = after_ff;
      cnt_in        = cnt_ff;
      cursor_in     = cursor_ff;
      start_in      = start_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      latched_in    = latched_ff;
      attr_in       = attr_ff;
      blank_in      = blank_ff;
      cmd_in        = cmd_ff;
      copy_v_in     = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      char_in       = char_ff;
      eob_in        = eob_ff;
      rdcell_in     = rdcell_ff;
      data_in       = data_ff;
      walk_base_in  = walk_base_ff;
      copy_dst_in   = copy_dst_ff;
      copy_oob_in   = copy_oob_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_read_in   = rsp_read_ff;
      ram_we        = 1'b0;
      ram_waddr     = cursor_ff[ADDR_W-1:0];
      ram_wdata     = blank_ff;
      ram_re        = 1'b0;
      ram_raddr     = walk_addr[ADDR_W-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         unique case (csr_addr)
            tcce_pkg::CSR_CHAR_ATTR: attr_in  = csr_wdata[CHAR_W-1:0];
            tcce_pkg::CSR_BLANK:     blank_in = csr_wdata[CELL_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // Blanking pass over the whole RAM, one cell per cycle.
            ram_we    = 1'b1;
            ram_waddr = cnt_ff[ADDR_W-1:0];
            ram_wdata = blank_ff;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(tcce_pkg::MEMORY_CELLS - 1)) begin
               state_in = (cmd_ff == tcce_pkg::CMD_CLEAR) ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = req_tdata[1:0];
               char_in   = req_tdata[9:2];
               rdcell_in = req_tdata[22:10];
               eob_in    = req_tlast;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            data_in = '0;
            unique case (cmd_ff)
               tcce_pkg::CMD_CLEAR: begin
                  start_in   = '0;
                  cursor_in  = '0;
                  col_in     = '0;
                  row_in     = '0;
                  latched_in = '0;
                  cnt_in     = '0;
                  state_in   = ST_CLEAR;
               end
               tcce_pkg::CMD_READ: begin
                  if (rdcell_in_range) begin
                     ram_re    = 1'b1;
                     ram_raddr = ADDR_W'(rdcell_ff);
                     state_in  = ST_RDWAIT;
                  end else begin
                     state_in  = ST_DONE;
                  end
               end
               tcce_pkg::CMD_WRITE: begin
                  state_in = ST_DONE;
                  case (char_ff) inside
                     tcce_pkg::CH_NUL, tcce_pkg::CH_BEL, tcce_pkg::CH_HT, tcce_pkg::CH_VT: ;
                     tcce_pkg::CH_BS: begin
                        if (col_ff != '0) begin
                           col_in    = col_ff - COL_W'(1);
                           cursor_in = cursor_m1;
                           ram_we    = cursor_m1_in_range;
                           ram_waddr = cursor_m1[ADDR_W-1:0];
                        end
                     end
                     tcce_pkg::CH_DEL: begin
                        ram_we = cursor_in_range;
                     end
                     tcce_pkg::CH_CR: begin
                        cursor_in = cursor_ff - POS_W'(col_ff);
                        col_in    = '0;
                     end
                     tcce_pkg::CH_LF: begin
                        after_in = AFT_CR;
                        state_in = ST_LF;
                     end
                     tcce_pkg::CH_FF: begin
                        after_in = AFT_NONE;
                        state_in = ST_LF;
                     end
                     default: begin
                        // Printable byte; a pending wrap first moves to the next line.
                        after_in = AFT_PUT;
                        if (col_ff >= COL_W'(tcce_pkg::COLUMNS)) begin
                           col_in    = col_ff - COL_W'(tcce_pkg::COLUMNS);
                           cursor_in = cursor_ff - POS_W'(tcce_pkg::COLUMNS);
                           state_in  = ST_LF;
                        end else begin
                           state_in  = ST_AFTER;
                        end
                     end
                  endcase
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_RDWAIT: begin
            data_in  = ram_rdata;
            state_in = ST_DONE;
         end
         ST_LF: begin
            cnt_in = '0;
            if (row_p1 < (ROW_W + 1)'(tcce_pkg::ROWS)) begin
               row_in    = row_p1[ROW_W-1:0];
               cursor_in = cursor_ff + POS_W'(tcce_pkg::COLUMNS);
               state_in  = ST_AFTER;
            end else if (!room_for_row) begin
               walk_base_in = start_ff;
               state_in     = ST_RELOC;
            end else begin
               walk_base_in = start_ff + POS_W'(tcce_pkg::SCREEN_CELLS);
               state_in     = ST_BLANK;
            end
         end
         ST_RELOC: begin
            // Ascending copy of the visible screen to cell 0: the read issued in one
            // cycle is written back in the next, so reads run one cell ahead.
            if (copy_v_ff) begin
               ram_we    = copy_dst_in_range;
               ram_waddr = copy_dst_ff[ADDR_W-1:0];
               ram_wdata = copy_oob_ff ? '0 : ram_rdata;
            end
            if (cnt_ff < CNT_W'(tcce_pkg::SCREEN_CELLS)) begin
               ram_re      = walk_in_range;
               ram_raddr   = walk_addr[ADDR_W-1:0];
               copy_v_in   = 1'b1;
               copy_dst_in = cnt_ff;
               copy_oob_in = !walk_in_range;
               cnt_in      = cnt_ff + CNT_W'(1);
            end else begin
               cursor_in    = cursor_ff - start_ff;
               start_in     = '0;
               cnt_in       = '0;
               walk_base_in = POS_W'(tcce_pkg::SCREEN_CELLS);
               state_in     = ST_BLANK;
            end
         end
         ST_BLANK: begin
            // Blank the row just below the visible screen, then move the start down.
            ram_we    = walk_in_range;
            ram_waddr = walk_addr[ADDR_W-1:0];
            ram_wdata = blank_ff;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(tcce_pkg::COLUMNS - 1)) begin
               start_in  = start_ff + POS_W'(tcce_pkg::COLUMNS);
               cursor_in = cursor_ff + POS_W'(tcce_pkg::COLUMNS);
               state_in  = ST_AFTER;
            end
         end
         ST_AFTER: begin
            state_in = ST_DONE;
            unique case (after_ff)
               AFT_CR: begin
                  cursor_in = cursor_ff - POS_W'(col_ff);
                  col_in    = '0;
               end
               AFT_PUT: begin
                  ram_we    = cursor_in_range;
                  ram_wdata = {attr_ff, char_ff};
                  cursor_in = cursor_ff + POS_W'(1);
                  col_in    = col_ff + COL_W'(1);
               end
               default: ;
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if ((cmd_ff == tcce_pkg::CMD_WRITE) && eob_ff) begin
                  latched_in = cursor_ff;
               end
               rsp_valid_in  = 1'b1;
               rsp_cursor_in = latched_in[OFFSET_W-1:0];
               rsp_start_in  = start_ff[OFFSET_W-1:0];
               rsp_read_in   = data_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         after_ff     <= AFT_NONE;
         cnt_ff       <= '0;
         cursor_ff    <= '0;
         start_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         latched_ff   <= '0;
         attr_ff      <= tcce_pkg::ATTR_RESET;
         blank_ff     <= tcce_pkg::BLANK_RESET;
         cmd_ff       <= tcce_pkg::CMD_WRITE;
         copy_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         cnt_ff       <= cnt_in;
         cursor_ff    <= cursor_in;
         start_ff     <= start_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         latched_ff   <= latched_in;
         attr_ff      <= attr_in;
         blank_ff     <= blank_in;
         cmd_ff       <= cmd_in;
         copy_v_ff    <= copy_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      eob_ff        <= eob_in;
      rdcell_ff     <= rdcell_in;
      data_ff       <= data_in;
      walk_base_ff  <= walk_base_in;
      copy_dst_ff   <= copy_dst_in;
      copy_oob_ff   <= copy_oob_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_read_ff   <= rsp_read_in;
   end

   tcce_ram #(
      .WIDTH (CELL_W),
      .DEPTH (tcce_pkg::MEMORY_CELLS)
   ) u_video_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // An accepted request always starts decoding in the following cycle.
   `TCCE_ASSERT_NXT(a_accept_to_exec, clock, reset, req_tvalid && req_tready, state_ff == ST_EXEC)
   // Between items the cursor never lies above the first visible cell.
   `TCCE_ASSERT_IMP(a_cursor_after_start, clock, reset, state_ff == ST_IDLE, cursor_ff >= start_ff)
   // The column holds at most one pending wrap past the last column.
   `TCCE_ASSERT_IMP(a_col_bound, clock, reset, 1'b1, col_ff <= COL_W'(tcce_pkg::COLUMNS))
   // The row stays on the screen.
   `TCCE_ASSERT_IMP(a_row_bound, clock, reset, 1'b1,
                    (ROW_W + 1)'(row_ff) < (ROW_W + 1)'(tcce_pkg::ROWS))

endmodule
